// File: rtl/core/qalu_pkg.sv
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types, widths and helpers for the quaternion ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qalu_pkg;

    localparam int Q_W       = 16;  // Q8.8 component
    localparam int ADD_W     = 17;
    localparam int PROD_W    = 32;  // Q16.16 product
    localparam int SUM_W     = 34;  // four products summed
    localparam int NORM_W    = 33;
    localparam int REM_W     = 41;  // |p|*256 + norm/2
    localparam int QUO_W     = 17;
    localparam int CMP_W     = 51;
    localparam int RND_W     = 27;  // rounded product before saturation
    localparam int DIV_STAGES = QUO_W + 1;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [3:0][Q_W-1:0]      l;
        logic [3:0][Q_W-1:0]      r;
    } operand_t;

    typedef struct packed {
        logic [1:0]               op;
        logic [3:0][ADD_W-1:0]    addsub;
        logic [15:0][PROD_W-1:0]  prod;   // l[i]*r[j] at 4*i+j
        logic [3:0][PROD_W-1:0]   sq;
    } prod_t;

    typedef struct packed {
        logic [1:0]               op;
        logic [3:0][ADD_W-1:0]    addsub;
        logic [3:0][SUM_W-1:0]    pq;
        logic [NORM_W-1:0]        norm;
    } sum_t;

    typedef struct packed {
        logic                     is_div;
        logic                     dz;
        logic                     ovf;
        logic [3:0][Q_W-1:0]      res;
        logic [3:0]               neg;
        logic [3:0]               hi;
        logic [3:0][REM_W-1:0]    rem;
        logic [3:0][QUO_W-1:0]    quo;
        logic [NORM_W-1:0]        norm;
    } div_t;

    // returns {overflow, value}
    function automatic logic [Q_W:0] sat_q(input logic signed [RND_W-1:0] v);
        logic [Q_W:0] r;
        if (v > RND_W'(signed'(32767)))
            r = {1'b1, 16'h7FFF};
        else if (v < -RND_W'(signed'(32768)))
            r = {1'b1, 16'h8000};
        else
            r = {1'b0, v[Q_W-1:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/qalu_prod.sv
// ----------------------------------------------------------------------------
// qalu_prod
// First stage: all cross products, squares of the right operand, add/sub.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_prod
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire qalu_pkg::operand_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output qalu_pkg::prod_t        out_data
);

    logic             v_reg;
    qalu_pkg::prod_t  d_reg;
    qalu_pkg::prod_t  d_next;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        d_next.op = in_data.op;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                d_next.prod[4*i+j] = qalu_pkg::PROD_W'(
                    signed'(in_data.l[i]) * signed'(in_data.r[j]));
            end
            d_next.sq[i] = qalu_pkg::PROD_W'(
                signed'(in_data.r[i]) * signed'(in_data.r[i]));
            if (in_data.op == qalu_pkg::OP_SUB)
                d_next.addsub[i] = qalu_pkg::ADD_W'(signed'(in_data.l[i]))
                                 - qalu_pkg::ADD_W'(signed'(in_data.r[i]));
            else
                d_next.addsub[i] = qalu_pkg::ADD_W'(signed'(in_data.l[i]))
                                 + qalu_pkg::ADD_W'(signed'(in_data.r[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/qalu_sum.sv
// ----------------------------------------------------------------------------
// qalu_sum
// Second stage: signed sums of products (Hamilton or conjugate form), norm.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_sum
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire qalu_pkg::prod_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output qalu_pkg::sum_t        out_data
);

    logic            v_reg;
    qalu_pkg::sum_t  d_reg;
    qalu_pkg::sum_t  d_next;
    logic signed [qalu_pkg::SUM_W-1:0] p [16];

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        for (int n = 0; n < 16; n++)
            p[n] = qalu_pkg::SUM_W'(signed'(in_data.prod[n]));
    end

    always_comb
    begin
        d_next.op     = in_data.op;
        d_next.addsub = in_data.addsub;
        d_next.norm   = qalu_pkg::NORM_W'(in_data.sq[0]) + qalu_pkg::NORM_W'(in_data.sq[1])
                      + qalu_pkg::NORM_W'(in_data.sq[2]) + qalu_pkg::NORM_W'(in_data.sq[3]);
        if (in_data.op == qalu_pkg::OP_DIV)
        begin
            // left times conjugate of right
            d_next.pq[0] =  p[0]  + p[5]  + p[10] + p[15];
            d_next.pq[1] = -p[1]  + p[4]  - p[11] + p[14];
            d_next.pq[2] = -p[2]  + p[7]  + p[8]  - p[13];
            d_next.pq[3] = -p[3]  - p[6]  + p[9]  + p[12];
        end
        else
        begin
            d_next.pq[0] =  p[0]  - p[5]  - p[10] - p[15];
            d_next.pq[1] =  p[1]  + p[4]  + p[11] - p[14];
            d_next.pq[2] =  p[2]  - p[7]  + p[8]  + p[13];
            d_next.pq[3] =  p[3]  + p[6]  - p[9]  + p[12];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/qalu_prep.sv
// ----------------------------------------------------------------------------
// qalu_prep
// Third stage: finish add/sub/mul results, set up the dividend for divide.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_prep
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire qalu_pkg::sum_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output qalu_pkg::div_t       out_data
);

    logic            v_reg;
    qalu_pkg::div_t  d_reg;
    qalu_pkg::div_t  d_next;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        logic signed [qalu_pkg::SUM_W:0]   t;
        logic signed [qalu_pkg::RND_W-1:0] rv;
        logic [qalu_pkg::Q_W:0]            s;
        logic [qalu_pkg::SUM_W-1:0]        m;

        d_next        = '0;
        d_next.is_div = (in_data.op == qalu_pkg::OP_DIV);
        d_next.dz     = d_next.is_div && (in_data.norm == '0);
        d_next.norm   = in_data.norm;
        for (int i = 0; i < 4; i++)
        begin
            // round half up: (p + 128) >> 8
            t  = (qalu_pkg::SUM_W+1)'(signed'(in_data.pq[i])) + 35'sd128;
            if (in_data.op == qalu_pkg::OP_MUL)
                rv = qalu_pkg::RND_W'(t >>> 8);
            else
                rv = qalu_pkg::RND_W'(signed'(in_data.addsub[i]));
            s = qalu_pkg::sat_q(rv);
            d_next.res[i] = s[qalu_pkg::Q_W-1:0];
            if (!d_next.is_div && s[qalu_pkg::Q_W])
                d_next.ovf = 1'b1;

            d_next.neg[i] = in_data.pq[i][qalu_pkg::SUM_W-1];
            m = d_next.neg[i] ? (~in_data.pq[i] + 1'b1) : in_data.pq[i];
            d_next.rem[i] = {m[qalu_pkg::REM_W-9:0], 8'b0}
                          + qalu_pkg::REM_W'(in_data.norm >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/qalu_div.sv
// ----------------------------------------------------------------------------
// qalu_div
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// First stage flags quotients too large for 17 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_div
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire qalu_pkg::div_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output qalu_pkg::div_t       out_data
);

    localparam int NS = qalu_pkg::DIV_STAGES;

    qalu_pkg::div_t  st_reg [NS];
    logic [NS-1:0]   v_reg;
    logic [NS:0]     rdy;

    assign rdy[NS]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = st_reg[NS-1];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        // quotient bit settled by this stage
        localparam int QB = (k == 0) ? 0 : NS - 1 - k;

        qalu_pkg::div_t src;
        qalu_pkg::div_t st_next;
        logic           src_v;

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        if (k == 0)
        begin : g_first
            assign src   = in_data;
            assign src_v = in_valid;
        end
        else
        begin : g_chain
            assign src   = st_reg[k-1];
            assign src_v = v_reg[k-1];
        end

        always_comb
        begin
            logic [qalu_pkg::CMP_W-1:0] diff;
            st_next = src;
            for (int l = 0; l < 4; l++)
            begin
                if (k == 0)
                begin
                    diff = qalu_pkg::CMP_W'(src.rem[l])
                         - (qalu_pkg::CMP_W'(src.norm) << qalu_pkg::QUO_W);
                    st_next.hi[l] = !diff[qalu_pkg::CMP_W-1];
                end
                else
                begin
                    diff = qalu_pkg::CMP_W'(src.rem[l])
                         - (qalu_pkg::CMP_W'(src.norm) << QB);
                    if (!diff[qalu_pkg::CMP_W-1])
                    begin
                        st_next.rem[l]     = diff[qalu_pkg::REM_W-1:0];
                        st_next.quo[l][QB] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (rdy[k])
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_v)
                st_reg[k] <= st_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/quaternion_alu.sv
// ----------------------------------------------------------------------------
// quaternion_alu
// Pipelined quaternion add / subtract / multiply / divide in signed Q8.8.
//
//   channel  dir  payload
//   s_axis   in   tdata: 8 x Q8.8 operand parts, tuser: operation
//   m_axis   out  tdata: 4 x Q8.8 result parts, tuser: overflow, divide_by_zero
//
// One transaction per cycle unless the output stalls; stages: products, sums,
// setup, 18 divider stages, output register; the divider sets the depth.
// rst_n clears every stage valid bit; payload is not reset.
// A stall at the output backs up stage by stage; empty stages keep taking.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_alu
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // left_real, left_i, left_j, left_k, right_real, right_i, right_j, right_k
    input  wire logic [127:0]  s_axis_tdata,
    // operation
    input  wire logic [1:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // out_real, out_i, out_j, out_k
    output logic [63:0]        m_axis_tdata,
    // overflow, divide_by_zero
    output logic [1:0]         m_axis_tuser
);

    qalu_pkg::operand_t opnd;
    qalu_pkg::prod_t    prod_d;
    qalu_pkg::sum_t     sum_d;
    qalu_pkg::div_t     prep_d;
    qalu_pkg::div_t     div_d;
    logic prod_v, prod_r, sum_v, sum_r, prep_v, prep_r, div_v, div_r;

    logic        out_v_reg;
    logic [63:0] data_reg;
    logic [63:0] data_next;
    logic [1:0]  flag_reg;
    logic [1:0]  flag_next;

    always_comb
    begin
        opnd.op = s_axis_tuser;
        for (int i = 0; i < 4; i++)
        begin
            opnd.l[i] = s_axis_tdata[16*i +: 16];
            opnd.r[i] = s_axis_tdata[64 + 16*i +: 16];
        end
    end

    qalu_prod u_prod
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(opnd),
        .out_valid(prod_v), .out_ready(prod_r), .out_data(prod_d)
    );

    qalu_sum u_sum
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(prod_v), .in_ready(prod_r), .in_data(prod_d),
        .out_valid(sum_v), .out_ready(sum_r), .out_data(sum_d)
    );

    qalu_prep u_prep
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(sum_v), .in_ready(sum_r), .in_data(sum_d),
        .out_valid(prep_v), .out_ready(prep_r), .out_data(prep_d)
    );

    qalu_div u_div
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(prep_v), .in_ready(prep_r), .in_data(prep_d),
        .out_valid(div_v), .out_ready(div_r), .out_data(div_d)
    );

    assign div_r = !out_v_reg || m_axis_tready;

    // quotient sign, saturation, zero divisor
    always_comb
    begin
        logic ovf;
        ovf = div_d.ovf;
        for (int i = 0; i < 4; i++)
        begin
            data_next[16*i +: 16] = div_d.res[i];
            if (div_d.is_div)
            begin
                if (div_d.dz)
                    data_next[16*i +: 16] = '0;
                else if (!div_d.neg[i])
                begin
                    if (div_d.hi[i] || div_d.quo[i] > 17'd32767)
                    begin
                        data_next[16*i +: 16] = 16'h7FFF;
                        ovf = 1'b1;
                    end
                    else
                        data_next[16*i +: 16] = div_d.quo[i][15:0];
                end
                else
                begin
                    if (div_d.hi[i] || div_d.quo[i] > 17'd32768)
                    begin
                        data_next[16*i +: 16] = 16'h8000;
                        ovf = 1'b1;
                    end
                    else
                        data_next[16*i +: 16] = ~div_d.quo[i][15:0] + 1'b1;
                end
            end
        end
        if (div_d.dz)
            ovf = 1'b0;
        flag_next = {div_d.dz, ovf};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (div_r)
            out_v_reg <= div_v;
    end

    always_ff @(posedge clk)
    begin
        if (div_r && div_v)
        begin
            data_reg <= data_next;
            flag_reg <= flag_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = flag_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
        else $error("zero divisor result not cleared");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipe refused input with empty output");

    a_dz_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        div_v && div_d.dz |-> div_d.is_div)
        else $error("zero divisor flag on non-divide");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        div_v && !div_r |=> div_v)
        else $error("divider output dropped under stall");

endmodule

`default_nettype wire
